// ===== design/kch_pkg.sv =====
// Shared types and constants for the k-mer count histogram.
package kch_pkg;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  read_char;
      logic        read_start;
      logic [15:0] query_index;
   } req_type;

   typedef struct packed {
      logic [15:0] kmer_index;
      logic [31:0] count_value;
   } rsp_type;

   localparam int unsigned POS_BITS   = 6;
   localparam int unsigned POS_MAX    = 63;
   localparam int unsigned SKIP_CHARS = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_THREE = 8'h33;

endpackage

// ===== design/kmer_count_histogram.sv =====
// Top level of the k-mer count histogram: count store, update pipeline, query output.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data) takes one item per cycle unless
//    stalled. opcode PUSH feeds one read character; read_start marks a new read.
//    The first two characters of a read are skipped, later ones extend an
//    8-base window, and each countable window bumps one saturating counter.
//  - opcode QUERY returns one rsp item with the count of query_index (low
//    2*KMER_LEN bits select the entry; kmer_index echoes the full index).
//  - Throughput: one item per cycle when not stalled, set by the single
//    read-modify-write pass on the count memory (read on accept, write in the
//    cycle after). Repeated k-mers in consecutive cycles are handled by a
//    write-back forwarding register.
//  - A query passes the update stage, then the output register, which raises
//    rsp_valid for its result.
//  - Reset: all 4^KMER_LEN entries (65536 at default) of the count memory
//    are swept to zero, one entry per cycle; req_stall is high until done.
//  - rsp_stall: the result sits in the output register; a second query can
//    wait in the update stage, and only then does req_stall rise.
module kmer_count_histogram
   import kch_pkg::*;
#(
   parameter int unsigned KMER_LEN   = 8,
   parameter int unsigned READ_LEN   = 50,
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned ADDR_BITS = 2 * KMER_LEN;
   localparam int unsigned DEPTH     = 1 << ADDR_BITS;

   // count memory
   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;

   // clear sweep
   logic                 clearing_ff, clearing_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   // front end
   logic                 accept, push;
   logic [ADDR_BITS-1:0] window_next, rd_addr, query_addr;
   logic [31:0]          query_wide;
   logic                 count_en;

   // update stage
   logic                  s1_valid_ff, s1_valid_in;
   opcode_type            s1_op_ff;
   logic [ADDR_BITS-1:0]  s1_addr_ff;
   logic [15:0]           s1_index_ff;
   logic [COUNT_BITS-1:0] cur_count, new_count;
   logic                  s1_block, wr_en;

   // last write, for forwarding to the entry just read
   logic                  wb_valid_ff;
   logic [ADDR_BITS-1:0]  wb_addr_ff;
   logic [COUNT_BITS-1:0] wb_data_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in, out_free;
   rsp_type rsp_data_ff;

   kch_window #(
      .KMER_LEN (KMER_LEN),
      .READ_LEN (READ_LEN)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .read_char   (req_data.read_char),
      .read_start  (req_data.read_start),
      .window_next (window_next),
      .count_en    (count_en)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s1_block  = s1_valid_ff && (s1_op_ff == OP_QUERY) && !out_free;
      req_stall = clearing_ff || s1_block;
      accept    = req_valid && !req_stall;
      push      = accept && (req_data.opcode == OP_PUSH);

      query_wide = 32'(req_data.query_index);
      query_addr = query_wide[ADDR_BITS-1:0];
      rd_addr    = (req_data.opcode == OP_QUERY) ? query_addr : window_next;

      // a push that counts nothing leaves no trace in the update stage
      s1_valid_in = accept && ((req_data.opcode == OP_QUERY) || count_en);

      // the memory read misses a write made on the same edge
      if (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) begin
         cur_count = wb_data_ff;
      end else begin
         cur_count = rd_data_ff;
      end
      new_count = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count : cur_count + 1'b1;
      wr_en     = s1_valid_ff && (s1_op_ff == OP_PUSH);

      clearing_in = clearing_ff && (clr_addr_ff != {ADDR_BITS{1'b1}});
      clr_addr_in = clr_addr_ff + 1'b1;

      if (s1_valid_ff && (s1_op_ff == OP_QUERY) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // memory: clear sweep or counter write-back, plus one read per accept
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[s1_addr_ff] <= new_count;
      end
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clearing_ff <= clearing_in;
            clr_addr_ff <= clr_addr_in;
         end
         if (!s1_block) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (wr_en) begin
            wb_valid_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_data.opcode;
         s1_addr_ff  <= rd_addr;
         s1_index_ff <= req_data.query_index;
      end
      if (wr_en) begin
         wb_addr_ff <= s1_addr_ff;
         wb_data_ff <= new_count;
      end
      if (s1_valid_ff && (s1_op_ff == OP_QUERY) && out_free) begin
         rsp_data_ff.kmer_index  <= s1_index_ff;
         rsp_data_ff.count_value <= 32'(cur_count);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/kch_window.sv =====
// Read-side front end: character decode, position tracking and rolling k-mer window.
module kch_window
   import kch_pkg::*;
#(
   parameter int unsigned KMER_LEN = 8,
   parameter int unsigned READ_LEN = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              read_char,
   input  logic                    read_start,
   output logic [2*KMER_LEN-1:0]   window_next,
   output logic                    count_en
);

   localparam int unsigned WIN_BITS  = 2 * KMER_LEN;
   localparam int unsigned FIRST_POS = SKIP_CHARS + KMER_LEN - 1;
   localparam int unsigned END_POS   = SKIP_CHARS + READ_LEN - 1;

   logic [WIN_BITS-1:0] window_ff, window_in, window_base;
   logic [POS_BITS-1:0] pos_ff, pos_in, pos_cur;
   logic [1:0]          last_ff, last_in, last_cur, code;
   logic                base_ok;

   always_comb begin
      pos_cur     = read_start ? '0 : pos_ff;
      last_cur    = read_start ? 2'd0 : last_ff;
      window_base = read_start ? '0 : window_ff;

      if (read_char >= CHAR_ZERO && read_char <= CHAR_THREE) begin
         code = read_char[1:0];
      end else begin
         code = last_cur;
      end

      base_ok     = (pos_cur >= POS_BITS'(SKIP_CHARS));
      window_next = (window_base >> 2) | (WIN_BITS'(code) << (WIN_BITS - 2));
      count_en    = ({1'b0, pos_cur} >= 7'(FIRST_POS)) && ({1'b0, pos_cur} < 7'(END_POS));

      pos_in    = (pos_cur < POS_BITS'(POS_MAX)) ? pos_cur + 1'b1 : pos_cur;
      last_in   = base_ok ? code : last_cur;
      window_in = base_ok ? window_next : window_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         last_ff   <= '0;
      end else if (push) begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         last_ff   <= last_in;
      end
   end

endmodule

// ===== tb/sv/kmer_count_histogram_tb.sv =====
// Self-checking testbench for kmer_count_histogram: read streams, count queries, backpressure.
`timescale 1ns / 100ps

module kmer_count_histogram_tb
   import kch_pkg::*;
();

   localparam int unsigned KMER_LEN    = 8;
   localparam int unsigned READ_LEN    = 50;
   localparam int unsigned WIN_BITS    = 2 * KMER_LEN;
   localparam int unsigned STORE_DEPTH = 1 << WIN_BITS;
   localparam int unsigned FULL_READ   = READ_LEN + SKIP_CHARS;
   // Run limit; it covers the reset sweep of the whole store and every test.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_PRINTS  = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   kmer_count_histogram u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the histogram: counts, rolling window, read position.
   // ---------------------------------------------------------------------
   logic [31:0]         tally_mem [STORE_DEPTH];
   logic [WIN_BITS-1:0] win_code;
   int unsigned         char_pos;
   logic [1:0]          prev_base;
   rsp_type             expected_counts [$];  // query answers still owed
   logic [15:0]         recent_kmers [$];     // windows counted lately, for hit queries

   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_left     = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   // Apply one accepted item to the shadow state; a query owes one answer.
   function automatic void update_histogram(input req_type item);
      int unsigned pos;
      int unsigned base_idx;
      logic [1:0]  code;
      rsp_type     answer;
      if (item.opcode == OP_QUERY) begin
         answer.kmer_index  = item.query_index;
         answer.count_value = tally_mem[item.query_index[WIN_BITS-1:0]];
         expected_counts.push_back(answer);
         return;
      end
      if (item.read_start) begin
         char_pos  = 0;
         win_code  = '0;
         prev_base = 2'd0;
      end
      pos = char_pos;
      if (char_pos < POS_MAX) char_pos++;
      // leading characters of a read (primer and first color) carry no base
      if (pos < SKIP_CHARS) return;
      base_idx = pos - SKIP_CHARS;
      // '0'..'3' map to their low two bits; anything else repeats the last base
      code = (item.read_char >= CHAR_ZERO && item.read_char <= CHAR_THREE) ?
             item.read_char[1:0] : prev_base;
      prev_base = code;
      win_code  = {code, win_code[WIN_BITS-1:2]};
      if (base_idx + 1 >= KMER_LEN && base_idx + 1 - KMER_LEN < READ_LEN - KMER_LEN) begin
         // saturating bump; the 32-bit ceiling is out of reach in this run
         if (tally_mem[win_code] != '1) tally_mem[win_code]++;
         recent_kmers.push_back(win_code);
         if (recent_kmers.size() > 64) void'(recent_kmers.pop_front());
      end
   endfunction

   // Both handshakes are judged on the same rising edge: accepted requests
   // update the shadow first, then an accepted result is matched in order.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) update_histogram(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("result with none pending: index %h count %0d",
                                         rsp_data.kmer_index, rsp_data.count_value));
            end else begin
               want = expected_counts.pop_front();
               if (rsp_data.kmer_index !== want.kmer_index)
                  report_mismatch($sformatf("kmer_index %h, want %h",
                                            rsp_data.kmer_index, want.kmer_index));
               if (rsp_data.count_value !== want.count_value)
                  report_mismatch($sformatf("count of %h is %0d, want %0d",
                                            want.kmer_index, rsp_data.count_value,
                                            want.count_value));
            end
         end
      end
   end

   // Receiver: a long hold-off when requested, else random stall at the set rate.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Item builders and the request driver
   // ---------------------------------------------------------------------
   function automatic req_type make_push(input logic [7:0] ch, input logic start);
      req_type item;
      item.opcode      = OP_PUSH;
      item.read_char   = ch;
      item.read_start  = start;
      item.query_index = 16'($urandom_range(16'hFFFF));  // ignored on a push
      return item;
   endfunction

   function automatic req_type make_query(input logic [15:0] idx);
      req_type item;
      item.opcode      = OP_QUERY;
      item.read_char   = 8'($urandom_range(255));  // ignored on a query
      item.read_start  = 1'($urandom_range(1));
      item.query_index = idx;
      return item;
   endfunction

   // Mostly valid colors, some unknown calls, a few arbitrary bytes.
   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 85) return CHAR_ZERO + 8'($urandom_range(3));
      if (r < 95) return 8'h2E;  // '.'
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_query();
      if (recent_kmers.size() > 0 && $urandom_range(99) < 60)
         return recent_kmers[$urandom_range(recent_kmers.size() - 1)];
      return 16'($urandom_range(16'hFFFF));
   endfunction

   // Inputs move on the falling edge; valid stays high across back-to-back items.
   task automatic send_item(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Sender goes quiet until every owed answer has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   task automatic send_read(input int unsigned n_chars, input logic with_start);
      for (int unsigned i = 0; i < n_chars; i++) begin
         send_item(make_push(pick_char(), with_start && i == 0));
         // a query in mid-read must leave the read state alone
         if ($urandom_range(99) < 8) send_item(make_query(pick_query()));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Minimal read: one window only. Odd bytes in the skipped slots, an unknown
   // call right at read start (reads as base 0), an arbitrary byte repeating.
   task automatic test_short_read();
      logic [7:0] chars [10];
      chars = '{8'hFF, 8'h00, 8'h2E, 8'h33, 8'h32, 8'h31, 8'h30, 8'h80, 8'h33, 8'h33};
      for (int i = 0; i < 10; i++) send_item(make_push(chars[i], i == 0));
      // bases 0,3,2,1,0,0,3,3 with the oldest base in the low bits
      send_item(make_query(16'hF06C));
      send_item(make_query(16'hFFFF));
      send_item(make_query(16'h0000));
      wait_drained();
   endtask

   // Identical windows on consecutive cycles exercise write-back forwarding.
   task automatic test_repeated_kmer();
      send_item(make_push(8'h41, 1'b1));
      send_item(make_push(8'h30, 1'b0));
      for (int i = 0; i < 9; i++) send_item(make_push(8'h32, 1'b0));
      send_item(make_query(16'hAAAA));
      wait_drained();
   endtask

   // Mostly whole reads with random content; also short reads, run-on reads
   // without a start mark (position saturates), query bursts and loose noise.
   task automatic test_random_traffic(input int unsigned n_items,
                                      input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned first;
      int unsigned r;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first = items_sent;
      while (items_sent - first < n_items) begin
         r = $urandom_range(99);
         if (r < 65) begin
            send_read(FULL_READ, 1'b1);
         end else if (r < 77) begin
            send_read($urandom_range(1, FULL_READ - 1), 1'b1);
         end else if (r < 85) begin
            send_read($urandom_range(5, 40), 1'b0);
         end else if (r < 94) begin
            repeat ($urandom_range(1, 4)) send_item(make_query(pick_query()));
         end else begin
            send_item(make_push(8'($urandom_range(255)), 1'($urandom_range(1))));
         end
      end
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while queries keep coming, so the
   // output and update stages fill and the block must stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 0) send_item(make_push(pick_char(), 1'b0));
         send_item(make_query(pick_query()));
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset (the block then clears its store), directed, random, backpressure, random.
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) tally_mem[i] = '0;
      win_code  = '0;
      char_pos  = 0;
      prev_base = 2'd0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_read();
      test_repeated_kmer();
      test_random_traffic(500, 17, 87);
      test_backpressure();
      test_random_traffic(500, 87, 17);
      test_random_traffic(500, 0, 0);

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== kmer_count_histogram.f =====
design/kch_pkg.sv
design/kch_window.sv
design/kmer_count_histogram.sv
tb/sv/kmer_count_histogram_tb.sv
